>>> design/nsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

  // Framing characters of an NMEA 0183 sentence.
  localparam logic [7:0] StartChar = 8'h24;
  localparam logic [7:0] EndChar   = 8'h2A;

  localparam int unsigned IdLen  = 5;
  localparam int unsigned TagLen = 6;

  localparam int unsigned IdW  = 8 * IdLen;
  localparam int unsigned TagW = 8 * TagLen;
  localparam int unsigned CfgW = TagW;

  localparam logic [IdW-1:0]  SentenceIdReset = 40'h4750474741;
  localparam logic [TagW-1:0] TagBytesReset   = '0;

  // Configuration register indexes.
  localparam logic CfgSentenceId = 1'b0;
  localparam logic CfgTagBytes   = 1'b1;

  // Record capacity in bytes, tag bytes included.
  localparam int unsigned RecordCapacity = 128;
  localparam int unsigned RecLenW        = $clog2(RecordCapacity + 1);
  localparam logic [RecLenW-1:0] BodyLimit = RecLenW'(RecordCapacity - TagLen);

  // Depth of the command queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Index of the last byte in a header or trailer burst.
  localparam logic [2:0] BurstLastIdx = 3'd5;
  localparam logic [2:0] IdLastIdx    = 3'd4;

  typedef enum logic [1:0] {
    PhIdle,
    PhMatch,
    PhBody
  } phase_e;

  typedef enum logic [1:0] {
    CmdBody,
    CmdHeader,
    CmdTrailer
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       trunc;
  } cmd_t;

  // Byte k of the identifier, first byte most significant.
  function automatic logic [7:0] id_byte(logic [IdW-1:0] id, logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = id[39:32];
      3'd1:    b = id[31:24];
      3'd2:    b = id[23:16];
      3'd3:    b = id[15:8];
      default: b = id[7:0];
    endcase
    return b;
  endfunction

  // Byte k of the tag, first byte most significant.
  function automatic logic [7:0] tag_byte(logic [TagW-1:0] tag, logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = tag[47:40];
      3'd1:    b = tag[39:32];
      3'd2:    b = tag[31:24];
      3'd3:    b = tag[23:16];
      3'd4:    b = tag[15:8];
      default: b = tag[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> design/nsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module nsc_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [nsc_pkg::IdW-1:0]   sentence_id_i,
  input  wire logic                      in_valid_i,
  input  wire logic [7:0]                in_byte_i,
  output logic                           in_ready_o,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output nsc_pkg::cmd_t                  q_cmd_o
);

  nsc_pkg::phase_e               phase_q, phase_d;
  logic [2:0]                    pos_q, pos_d;
  logic [nsc_pkg::RecLenW-1:0]   len_q, len_d;
  logic                          ovf_q, ovf_d;
  logic                          accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nsc_pkg::PhIdle;
      pos_q   <= '0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    phase_d        = phase_q;
    pos_d          = pos_q;
    len_d          = len_q;
    ovf_d          = ovf_q;
    q_push_o       = 1'b0;
    q_cmd_o.kind   = nsc_pkg::CmdBody;
    q_cmd_o.data   = in_byte_i;
    q_cmd_o.trunc  = ovf_q;
    if (accept) begin
      case (phase_q)
        nsc_pkg::PhMatch: begin
          if (in_byte_i == nsc_pkg::id_byte(sentence_id_i, pos_q)) begin
            pos_d = pos_q + 3'd1;
            len_d = len_q + nsc_pkg::RecLenW'(1);
            if (pos_q == nsc_pkg::IdLastIdx) begin
              q_push_o      = 1'b1;
              q_cmd_o.kind  = nsc_pkg::CmdHeader;
              q_cmd_o.trunc = 1'b0;
              phase_d       = nsc_pkg::PhBody;
            end
          end else begin
            phase_d = nsc_pkg::PhIdle;
            pos_d   = '0;
          end
        end
        nsc_pkg::PhBody: begin
          if (in_byte_i == nsc_pkg::EndChar) begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = nsc_pkg::CmdTrailer;
            len_d        = len_q + nsc_pkg::RecLenW'(nsc_pkg::TagLen);
            phase_d      = nsc_pkg::PhIdle;
            pos_d        = '0;
          end else if (len_q < nsc_pkg::BodyLimit) begin
            q_push_o = 1'b1;
            len_d    = len_q + nsc_pkg::RecLenW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        default: begin
          // Idle, and the unused phase code, look for the start of a sentence.
          phase_d = nsc_pkg::PhIdle;
          if (in_byte_i == nsc_pkg::StartChar) begin
            phase_d = nsc_pkg::PhMatch;
            pos_d   = '0;
            len_d   = nsc_pkg::RecLenW'(1);
            ovf_d   = 1'b0;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/nsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module nsc_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire nsc_pkg::cmd_t push_cmd_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output nsc_pkg::cmd_t head_o,
  output logic         empty_o
);

  nsc_pkg::cmd_t                   mem_q [nsc_pkg::QueueDepth];
  logic [nsc_pkg::QueuePtrW-1:0]   wptr_q, rptr_q;
  logic [nsc_pkg::QueueCntW-1:0]   cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == nsc_pkg::QueueCntW'(nsc_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + nsc_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + nsc_pkg::QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + nsc_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - nsc_pkg::QueueCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/nsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module nsc_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [nsc_pkg::IdW-1:0]   sentence_id_i,
  input  wire logic [nsc_pkg::TagW-1:0]  tag_bytes_i,
  input  wire nsc_pkg::cmd_t             head_i,
  input  wire logic                      empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           out_last_o,
  output logic                           out_trunc_o
);

  logic          busy_q, busy_d;
  nsc_pkg::cmd_t cmd_q, cmd_d;
  logic [2:0]    cnt_q, cnt_d;
  logic          valid_q;
  logic [7:0]    byte_q;
  logic          last_q, trunc_q;

  nsc_pkg::cmd_t cur;
  logic          cur_valid;
  logic [2:0]    idx;
  logic          load;
  logic [7:0]    beat_byte;
  logic          beat_last;
  logic          burst_done;

  assign cur       = busy_q ? cmd_q : head_i;
  assign cur_valid = busy_q || !empty_i;
  assign idx       = busy_q ? cnt_q : 3'd0;
  assign load      = cur_valid && (!valid_q || out_ready_i);
  assign pop_o     = load && !busy_q;

  always_comb begin
    beat_byte  = cur.data;
    beat_last  = 1'b0;
    burst_done = 1'b1;
    case (cur.kind)
      nsc_pkg::CmdHeader: begin
        beat_byte  = (idx == 3'd0) ? nsc_pkg::StartChar
                                   : nsc_pkg::id_byte(sentence_id_i, idx - 3'd1);
        burst_done = (idx == nsc_pkg::BurstLastIdx);
      end
      nsc_pkg::CmdTrailer: begin
        beat_byte  = nsc_pkg::tag_byte(tag_bytes_i, idx);
        burst_done = (idx == nsc_pkg::BurstLastIdx);
        beat_last  = burst_done;
      end
      default: begin
        beat_byte = cur.data;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    cmd_d  = cmd_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = !burst_done;
      cmd_d  = cur;
      cnt_d  = idx + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (load) begin
      byte_q  <= beat_byte;
      last_q  <= beat_last;
      trunc_q <= cur.trunc;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_trunc_o = trunc_q;

endmodule

`default_nettype wire

>>> design/nmea_sentence_capture_top.sv
// NMEA sentence capture: filters a stream of received GPS bytes and passes on
// only the sentences whose five-byte identifier matches sentence_id.
// Input items arrive one byte each on the s_axis channel. Output items leave
// on the m_axis channel: a matched record starts with '$' and the identifier,
// carries the body bytes, and ends with the six tag bytes, the final one
// marked by tlast. tuser flags a record whose body was cut for capacity.
// A front stage classifies each byte and pushes a command into a four-entry
// queue; a back stage expands each command into output items.
// Throughput: one input item per cycle while the queue has room. A body byte
// yields one output item from the back stage; the byte that completes the
// identifier and the closing '*' each yield six output items, counted out by
// the back stage's burst counter. Other bytes produce nothing.
// The first output item of an accepted input is written into the queue, then
// into the back stage's output register, which drives m_axis_tvalid_o.
// When the receiver stalls, the output register holds its item, the back
// stage stops, the queue fills and then s_axis_tready_o drops.
// Reset clears the parse state, empties the queue and the output register,
// and loads the identifier GPGGA and an all-zero tag.
// Configuration is written through cfg_we_i, cfg_addr_i and cfg_wdata_i
// while the block is idle: index 0 the identifier, index 1 the tag.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_capture_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_addr_i,
  input  wire logic [nsc_pkg::CfgW-1:0]  cfg_wdata_i,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [7:0]                s_axis_tdata_i,   // [7:0] rx_byte
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o,   // [7:0] out_byte
  output logic                           m_axis_tlast_o,
  output logic                           m_axis_tuser_o    // [0] truncated
);

  logic [nsc_pkg::IdW-1:0]  sentence_id_q;
  logic [nsc_pkg::TagW-1:0] tag_bytes_q;

  // Configuration registers: the user must change them only while the datapath is idle; the block does not check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sentence_id_q <= nsc_pkg::SentenceIdReset;
      tag_bytes_q   <= nsc_pkg::TagBytesReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        nsc_pkg::CfgSentenceId: sentence_id_q <= cfg_wdata_i[nsc_pkg::IdW-1:0];
        default:                tag_bytes_q   <= cfg_wdata_i;
      endcase
    end
  end

  logic          q_push, q_full, q_pop, q_empty;
  nsc_pkg::cmd_t q_cmd, q_head;

  nsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sentence_id_i (sentence_id_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_byte_i     (s_axis_tdata_i),
    .in_ready_o    (s_axis_tready_o),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd)
  );

  nsc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  nsc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sentence_id_i (sentence_id_q),
    .tag_bytes_i   (tag_bytes_q),
    .head_i        (q_head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_byte_o    (m_axis_tdata_o),
    .out_last_o    (m_axis_tlast_o),
    .out_trunc_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

>>> test/tb_nmea_sentence_capture_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the NMEA sentence capture block. Received bytes go in
// on the input stream. A behavioral copy of the sentence filter runs alongside
// and queues the record bytes that each accepted byte must produce. The
// output stream is compared item by item against that queue.
module tb_nmea_sentence_capture_top;
  import nsc_pkg::*;

  // One expected output item.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       trunc;
  } rec_item_t;

  // One row of the directed table. When "given" is set, the row's results are
  // typed in here (count, bytes left-aligned, last on the final one, trunc
  // flag). Otherwise the behavioral filter supplies them.
  typedef struct {
    logic [7:0]  rx;
    bit          given;
    int          n;
    logic [47:0] bytes;
    logic        last;
    logic        trunc;
  } stim_row_t;

  localparam int NDir = 26;

  // Directed opening with the reset identifier GPGGA and the all-zero tag.
  // The bytes 8'h47, 8'h50 and 8'h41 are the letters G, P and A.
  stim_row_t dir_rows [NDir] = '{
    // Extreme bytes and a stray '*' while idle produce nothing.
    '{8'h00, 1, 0, 48'h0, 0, 0},
    '{8'hFF, 1, 0, 48'h0, 0, 0},
    '{8'h2A, 1, 0, 48'h0, 0, 0},
    // A full match on the reset identifier emits '$GPGGA' in one burst.
    '{8'h24, 1, 0, 48'h0, 0, 0},
    '{8'h47, 1, 0, 48'h0, 0, 0},
    '{8'h50, 1, 0, 48'h0, 0, 0},
    '{8'h47, 1, 0, 48'h0, 0, 0},
    '{8'h47, 1, 0, 48'h0, 0, 0},
    '{8'h41, 1, 6, 48'h24_47_50_47_47_41, 0, 0},
    // In the body a '$' is just data, as are the extreme bytes.
    '{8'h24, 1, 1, 48'h24_00_00_00_00_00, 0, 0},
    '{8'hFF, 1, 1, 48'hFF_00_00_00_00_00, 0, 0},
    '{8'h00, 1, 1, 48'h00_00_00_00_00_00, 0, 0},
    // The '*' appends the six zero tag bytes, the final one marked last.
    '{8'h2A, 1, 6, 48'h0, 1, 0},
    // Mismatch on a '$': the byte is dropped and not taken as a new start,
    // so the following 'G' finds the filter idle.
    '{8'h24, 1, 0, 48'h0, 0, 0},
    '{8'h47, 1, 0, 48'h0, 0, 0},
    '{8'h24, 1, 0, 48'h0, 0, 0},
    '{8'h47, 1, 0, 48'h0, 0, 0},
    // Mismatch right at the first identifier position.
    '{8'h24, 1, 0, 48'h0, 0, 0},
    '{8'h2A, 1, 0, 48'h0, 0, 0},
    // An empty-bodied record, left to the behavioral filter.
    '{8'h24, 0, 0, 48'h0, 0, 0},
    '{8'h47, 0, 0, 48'h0, 0, 0},
    '{8'h50, 0, 0, 48'h0, 0, 0},
    '{8'h47, 0, 0, 48'h0, 0, 0},
    '{8'h47, 0, 0, 48'h0, 0, 0},
    '{8'h41, 0, 0, 48'h0, 0, 0},
    '{8'h2A, 0, 0, 48'h0, 0, 0}
  };

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic            cfg_addr;
  logic [CfgW-1:0] cfg_wdata;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      in_byte;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [7:0]      out_byte;
  logic            out_last;
  logic            out_trunc;

  // Behavioral copy of the filter: configuration and parse state.
  logic [IdW-1:0]  want_id;
  logic [TagW-1:0] tag_val;
  phase_e          prs_phase;
  int              id_pos;
  int              rec_len;
  bit              dropped;

  rec_item_t record_q[$];  // record bytes still owed by the block
  int        errors = 0;
  bit        quiet = 1'b0; // when set, neither side idles
  int        stall_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  nmea_sentence_capture_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_byte),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_byte),
    .m_axis_tlast_o  (out_last),
    .m_axis_tuser_o  (out_trunc)
  );

  // Idle lengths for both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void note_result(logic [7:0] b, logic l, logic t, bit keep);
    if (keep) record_q.push_back('{b, l, t});
  endfunction

  // Advances the behavioral filter by one received byte. With keep set, the
  // record bytes that the byte causes are queued as expectations.
  function automatic void filter_byte(logic [7:0] b, bit keep);
    case (prs_phase)
      PhMatch: begin
        if (id_pos < IdLen && b == want_id[8*(IdLen-1-id_pos) +: 8]) begin
          id_pos++;
          rec_len++;
          if (id_pos >= IdLen) begin
            note_result(StartChar, 1'b0, 1'b0, keep);
            for (int k = 0; k < IdLen; k++)
              note_result(want_id[8*(IdLen-1-k) +: 8], 1'b0, 1'b0, keep);
            prs_phase = PhBody;
          end
        end else begin
          prs_phase = PhIdle;
          id_pos = 0;
        end
      end
      PhBody: begin
        if (b == EndChar) begin
          for (int k = 0; k < TagLen; k++)
            note_result(tag_val[8*(TagLen-1-k) +: 8], k == TagLen - 1, dropped, keep);
          rec_len += TagLen;
          prs_phase = PhIdle;
          id_pos = 0;
        end else if (rec_len + TagLen < RecordCapacity) begin
          note_result(b, 1'b0, dropped, keep);
          rec_len++;
        end else begin
          // Record is full: the byte is dropped and the record is flagged.
          dropped = 1'b1;
        end
      end
      default: begin
        prs_phase = PhIdle;
        if (b == StartChar) begin
          prs_phase = PhMatch;
          id_pos = 0;
          rec_len = 1;
          dropped = 1'b0;
        end
      end
    endcase
  endfunction

  // Offers one byte, optionally after an idle gap, and waits until it is
  // taken. The valid stays high afterwards so back-to-back items are offered
  // without a gap. Always entered right after a rising edge.
  task automatic send_byte(input logic [7:0] b, input bit keep = 1'b1);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    filter_byte(b, keep);
  endtask

  // Lowers the valid and waits for every owed record byte, then lets the
  // block's two-stage pipeline and command queue run dry.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (record_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges. Only called while idle.
  task automatic load_config(input logic [IdW-1:0] id, input logic [TagW-1:0] tag);
    cfg_we    <= 1'b1;
    cfg_addr  <= CfgSentenceId;
    // The bits above the identifier are don't-care; toggle them anyway.
    cfg_wdata <= {8'($urandom()), id};
    @(posedge clk);
    cfg_addr  <= CfgTagBytes;
    cfg_wdata <= tag;
    @(posedge clk);
    cfg_we    <= 1'b0;
    want_id = id;
    tag_val = tag;
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) return StartChar;
    do b = 8'($urandom()); while (b == EndChar);
    return b;
  endfunction

  // A well-formed sentence for the current identifier: '$', the five
  // identifier bytes, body_len body bytes and the closing '*'.
  task automatic send_sentence(input int body_len, inout int sent);
    send_byte(StartChar);
    for (int k = 0; k < IdLen; k++) send_byte(want_id[8*(IdLen-1-k) +: 8]);
    for (int k = 0; k < body_len; k++) send_byte(body_byte());
    send_byte(EndChar);
    sent += IdLen + body_len + 2;
  endtask

  // Random traffic: mostly well-formed sentences with random bodies, the
  // rest broken headers and line noise. A nonzero long_body places one
  // sentence with that many body bytes to reach the capacity limit. With
  // pause set, the sender once waits until all owed bytes have come.
  task automatic run_traffic(input int budget, input int long_body, input bit pause);
    int sent;
    int r;
    int pos;
    int noise;
    logic [7:0] b;
    logic [7:0] good;
    bit long_done;
    bit paused;
    sent = 0;
    long_done = (long_body == 0);
    paused = !pause;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (!long_done && sent > budget / 4) begin
        send_sentence(long_body, sent);
        long_done = 1'b1;
      end else if (r < 70) begin
        send_sentence($urandom_range(0, 99) < 85 ? $urandom_range(0, 6)
                                                 : $urandom_range(7, 20), sent);
      end else if (r < 85) begin
        // Header broken at a random position, sometimes by a '$'.
        pos = $urandom_range(0, IdLen - 1);
        send_byte(StartChar);
        for (int k = 0; k < pos; k++) send_byte(want_id[8*(IdLen-1-k) +: 8]);
        good = want_id[8*(IdLen-1-pos) +: 8];
        if ($urandom_range(0, 2) == 0 && good != StartChar) b = StartChar;
        else do b = 8'($urandom()); while (b == good);
        send_byte(b);
        sent += pos + 2;
      end else begin
        noise = $urandom_range(1, 4);
        repeat (noise) send_byte(8'($urandom()));
        sent += noise;
      end
      if (!paused && sent > budget / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  // Receiver: random stalls of the output stream.
  always @(posedge clk) begin : out_pacing
    int g;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      g = pick_gap();
      out_ready <= (g == 0);
      if (g > 0) stall_left = g - 1;
    end
  end

  // Checker: every accepted output item against the oldest expectation.
  always @(posedge clk) begin : out_check
    rec_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (record_q.size() == 0) begin
        $error("unexpected item: out_byte %h last %b truncated %b",
               out_byte, out_last, out_trunc);
        errors++;
      end else begin
        want = record_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_byte);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_last);
          errors++;
        end
        if (out_trunc !== want.trunc) begin
          $error("truncated: expected %b, got %b", want.trunc, out_trunc);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CfgSentenceId;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_byte   = '0;
    want_id   = SentenceIdReset;
    tag_val   = TagBytesReset;
    prs_phase = PhIdle;
    id_pos    = 0;
    rec_len   = 0;
    dropped   = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table on the reset configuration.
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].rx, !dir_rows[i].given);
      if (dir_rows[i].given)
        for (int k = 0; k < dir_rows[i].n; k++)
          record_q.push_back('{dir_rows[i].bytes[47-8*k -: 8],
                               dir_rows[i].last && k == dir_rows[i].n - 1,
                               dir_rows[i].trunc});
    end
    run_traffic(12, 0, 1'b0);

    // All-ones registers; a record that exactly fills the capacity.
    settle();
    load_config('1, '1);
    run_traffic(40, RecordCapacity - TagLen - IdLen - 1, 1'b1);

    // All-zero registers, with neither side idling.
    settle();
    quiet = 1'b1;
    load_config('0, '0);
    run_traffic(10, 0, 1'b0);
    quiet = 1'b0;

    // Random registers; a record that overflows by a few body bytes.
    settle();
    load_config(IdW'({$urandom(), $urandom()}), TagW'({$urandom(), $urandom()}));
    run_traffic(40, RecordCapacity - TagLen - IdLen + 2, 1'b0);

    // The RMC identifier with a random tag.
    settle();
    load_config(40'h4750524D43, TagW'({$urandom(), $urandom()}));
    run_traffic(10, 0, 1'b0);

    settle();
    repeat (20) @(posedge clk);
    if (record_q.size() != 0) begin
      $error("%0d record bytes never arrived", record_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[nmea_sentence_capture_top] OK");
    end else begin
      $display("[nmea_sentence_capture_top] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, in which every item waits
  // out a long sender gap and six results each wait out a long stall.
  initial begin
    #8_000_000;
    $display("[nmea_sentence_capture_top] ERROR");
    $finish;
  end

endmodule
